// File: sv/framed_remote_packet_decoder_top_assert.svh
// Assertion macros used by the checker file frpd_checker.
`ifndef FRAMED_REMOTE_PACKET_DECODER_TOP_ASSERT_SVH
`define FRAMED_REMOTE_PACKET_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FRPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/frpd_pkg.sv
package frpd_pkg;

  localparam int FRAME_BYTES_DEF = 17;
  // signed words start at frame position SIGNED_BYTES
  localparam int SIGNED_BYTES    = 8;
  localparam int WORD_BYTES      = 6;

  localparam logic [7:0] HEAD_RESET = 8'hA5;
  localparam logic [7:0] TAIL_RESET = 8'h5A;

  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_HEAD_BYTE = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_TAIL_BYTE = 1'b1;

  typedef enum logic [2:0] {
    P_WAIT  = 3'd0,
    P_EMIT  = 3'd1,
    P_CLR   = 3'd2,
    P_SCAN  = 3'd3,
    P_DRAIN = 3'd4,
    P_MIX   = 3'd5
  } step_t;

  typedef enum logic [1:0] {
    H_NONE,
    H_NO_ITEM,
    H_OUT_BUSY,
    H_SCAN_MORE
  } hold_t;

  typedef enum logic [1:0] {
    J_NONE,
    J_TAIL,
    J_ALWAYS
  } jump_t;

  typedef struct packed {
    logic  wait_in;
    logic  clr;
    logic  scan;
    logic  mix;
    logic  emit;
    hold_t hold;
    jump_t jump;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic is_tail;
    logic out_busy;
    logic scan_more;
  } seq_stat_t;

  // control store: hold has priority over jump, otherwise fall through to pc+1
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w = '{wait_in: 1'b0, clr: 1'b0, scan: 1'b0, mix: 1'b0, emit: 1'b0,
          hold: H_NONE, jump: J_NONE, target: P_WAIT};
    unique case (pc)
      P_WAIT: begin
        w.wait_in = 1'b1;
        w.hold    = H_NO_ITEM;
        w.jump    = J_TAIL;
        w.target  = P_CLR;
      end
      P_EMIT: begin
        w.emit   = 1'b1;
        w.hold   = H_OUT_BUSY;
        w.jump   = J_ALWAYS;
        w.target = P_WAIT;
      end
      P_CLR:   w.clr = 1'b1;
      P_SCAN: begin
        w.scan = 1'b1;
        w.hold = H_SCAN_MORE;
      end
      P_DRAIN: w.jump = J_NONE;
      P_MIX: begin
        w.mix    = 1'b1;
        w.jump   = J_ALWAYS;
        w.target = P_EMIT;
      end
      default: begin
        w.jump   = J_ALWAYS;
        w.target = P_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// File: sv/frpd_buf.sv
module frpd_buf
  import frpd_pkg::*;
#(
  parameter int DEPTH = FRAME_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [7:0]       q_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      q_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = q_vld_r ? q_r : 8'h00;

endmodule

// File: sv/frpd_seq.sv
module frpd_seq
  import frpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output uword_t    uw
);

  step_t pc_r, pc_nxt;
  logic  hold_met, jump_met;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uw = ucode(pc_r);
    unique case (uw.hold)
      H_NONE:      hold_met = 1'b0;
      H_NO_ITEM:   hold_met = !stat.in_valid;
      H_OUT_BUSY:  hold_met = stat.out_busy;
      H_SCAN_MORE: hold_met = stat.scan_more;
      default:     hold_met = 1'b0;
    endcase
    unique case (uw.jump)
      J_NONE:   jump_met = 1'b0;
      J_TAIL:   jump_met = stat.is_tail;
      J_ALWAYS: jump_met = 1'b1;
      default:  jump_met = 1'b0;
    endcase
    priority if (hold_met) begin
      pc_nxt = pc_r;
    end else if (jump_met) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = step_t'(pc_r + 3'd1);
    end
  end

endmodule

// File: sv/framed_remote_packet_decoder_top.sv
// Channel  Direction  Handshake         Payload
// in       input      in_valid/stall    in_rx_byte
// out      output     out_valid/stall   flags, four wheel mixes, three arm words, grip
// cfg      input      cfg_we            cfg_index, cfg_wdata (head byte, tail byte)
// Head, payload and ignored bytes are accepted in P_WAIT, then the output register is loaded
// in P_EMIT. A tail byte passes P_CLR, P_SCAN, P_DRAIN, P_MIX and P_EMIT: the checksum and
// unpack scan read the frame buffer through its single read port, one byte per cycle.
// rst_n is synchronous: clears the sequencer, count, frame flag, buffer valid bits, read valid
// and output valid, and sets head/tail to 0xA5/0x5A. A stalled result holds in the output
// register; input stays stalled until the pending result has moved into that register.
module framed_remote_packet_decoder_top
  import frpd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_byte_accepted,
  output logic               out_frame_done,
  output logic               out_check_ok,
  output logic               out_remote_enable,
  output logic signed [9:0]  out_wheel_a,
  output logic signed [9:0]  out_wheel_b,
  output logic signed [9:0]  out_wheel_c,
  output logic signed [9:0]  out_wheel_d,
  output logic signed [15:0] out_arm_first_tenths,
  output logic signed [15:0] out_arm_second_tenths,
  output logic signed [15:0] out_arm_third_tenths,
  output logic signed [7:0]  out_grip_value,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [7:0]         cfg_wdata
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam logic [AW-1:0] LAST_POS = AW'(FRAME_BYTES - 1);

  uword_t    uw;
  seq_stat_t stat;

  logic [7:0] head_r, head_nxt, tail_r, tail_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] addr_r, addr_nxt, pos_r;
  logic          rd_vld_r;
  logic [7:0]    rd_data;

  logic is_head, is_tail, store, accept;

  // scan captures
  logic [7:0] sum_r, sum_nxt, last_r, last_nxt;
  logic       nz_r, nz_nxt;
  logic [7:0] b1_r, b1_nxt, b2_r, b2_nxt, b3_r, b3_nxt, grip_r, grip_nxt;
  logic [WORD_BYTES-1:0][7:0] w_r, w_nxt;

  // pending result
  logic res_acc_r, res_acc_nxt, res_done_r, res_done_nxt;
  logic res_ok_r, res_ok_nxt, res_en_r, res_en_nxt;
  logic signed [9:0] wa_r, wa_nxt, wb_r, wb_nxt, wc_r, wc_nxt, wd_r, wd_nxt;
  logic signed [9:0] f_x, s_x, t_x;

  logic out_valid_r, out_valid_nxt;

  assign is_head = (in_rx_byte == head_r);
  assign is_tail = !is_head && (in_rx_byte == tail_r);
  assign store   = !is_head && !is_tail && in_frame_r && (count_r < CW'(FRAME_BYTES));
  assign in_stall = !uw.wait_in;
  assign accept   = in_valid && !in_stall;

  assign stat = '{in_valid:  in_valid,
                  is_tail:   is_tail,
                  out_busy:  out_valid_r && out_stall,
                  scan_more: addr_r != LAST_POS};

  frpd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uw    (uw)
  );

  frpd_buf #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && store),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    addr_nxt     = addr_r;
    sum_nxt  = sum_r;
    last_nxt = last_r;
    nz_nxt   = nz_r;
    b1_nxt   = b1_r;
    b2_nxt   = b2_r;
    b3_nxt   = b3_r;
    grip_nxt = grip_r;
    w_nxt    = w_r;
    res_acc_nxt  = res_acc_r;
    res_done_nxt = res_done_r;
    res_ok_nxt   = res_ok_r;
    res_en_nxt   = res_en_r;
    wa_nxt = wa_r;
    wb_nxt = wb_r;
    wc_nxt = wc_r;
    wd_nxt = wd_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD_BYTE: head_nxt = cfg_wdata;
        CFG_TAIL_BYTE: tail_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (accept) begin
      if (is_head) begin
        count_nxt    = '0;
        in_frame_nxt = 1'b1;
      end else if (is_tail) begin
        in_frame_nxt = 1'b0;
      end else if (store) begin
        count_nxt = count_r + CW'(1);
      end
      res_acc_nxt  = is_head || is_tail || store;
      res_done_nxt = is_tail;
      res_ok_nxt   = 1'b0;
      res_en_nxt   = 1'b0;
    end

    if (uw.clr) begin
      addr_nxt = '0;
      sum_nxt  = '0;
      nz_nxt   = 1'b0;
      b1_nxt   = '0;
      b2_nxt   = '0;
      b3_nxt   = '0;
      grip_nxt = '0;
      w_nxt    = '0;
    end

    if (uw.scan) begin
      addr_nxt = addr_r + AW'(1);
    end

    // byte at pos_r arrives in the cycle after its read was issued
    if (rd_vld_r) begin
      if (pos_r == LAST_POS) begin
        last_nxt = rd_data;
      end else begin
        sum_nxt = sum_r + rd_data;
      end
      if (pos_r == AW'(0)) nz_nxt   = (rd_data != 8'h00);
      if (pos_r == AW'(1)) b1_nxt   = rd_data;
      if (pos_r == AW'(2)) b2_nxt   = rd_data;
      if (pos_r == AW'(3)) b3_nxt   = rd_data;
      if (pos_r == AW'(4)) grip_nxt = rd_data;
      for (int k = 0; k < WORD_BYTES; k++) begin
        if (32'(pos_r) == 32'(SIGNED_BYTES + k)) w_nxt[k] = rd_data;
      end
    end

    f_x = {{2{b1_r[7]}}, b1_r};
    s_x = {{2{b2_r[7]}}, b2_r};
    t_x = {{2{b3_r[7]}}, b3_r};
    if (uw.mix) begin
      res_ok_nxt = (sum_r == last_r);
      res_en_nxt = (sum_r == last_r) && nz_r;
      wa_nxt = f_x + s_x + t_x;
      wb_nxt = f_x - s_x + t_x;
      wc_nxt = f_x + s_x - t_x;
      wd_nxt = f_x - s_x - t_x;
    end

    if (uw.emit && !(out_valid_r && out_stall)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= HEAD_RESET;
      tail_r      <= TAIL_RESET;
      in_frame_r  <= 1'b0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      in_frame_r  <= in_frame_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= uw.scan;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    pos_r      <= addr_r;
    sum_r      <= sum_nxt;
    last_r     <= last_nxt;
    nz_r       <= nz_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    b3_r       <= b3_nxt;
    grip_r     <= grip_nxt;
    w_r        <= w_nxt;
    res_acc_r  <= res_acc_nxt;
    res_done_r <= res_done_nxt;
    res_ok_r   <= res_ok_nxt;
    res_en_r   <= res_en_nxt;
    wa_r       <= wa_nxt;
    wb_r       <= wb_nxt;
    wc_r       <= wc_nxt;
    wd_r       <= wd_nxt;
  end

  // output register, loaded from the pending result
  always_ff @(posedge clk) begin
    if (uw.emit && !(out_valid_r && out_stall)) begin
      out_byte_accepted     <= res_acc_r;
      out_frame_done        <= res_done_r;
      out_check_ok          <= res_ok_r;
      out_remote_enable     <= res_en_r;
      out_wheel_a           <= res_en_r ? wa_r : 10'sd0;
      out_wheel_b           <= res_en_r ? wb_r : 10'sd0;
      out_wheel_c           <= res_en_r ? wc_r : 10'sd0;
      out_wheel_d           <= res_en_r ? wd_r : 10'sd0;
      out_arm_first_tenths  <= res_en_r ? {w_r[1], w_r[0]} : 16'sd0;
      out_arm_second_tenths <= res_en_r ? {w_r[3], w_r[2]} : 16'sd0;
      out_arm_third_tenths  <= res_en_r ? {w_r[5], w_r[4]} : 16'sd0;
      out_grip_value        <= res_en_r ? grip_r : 8'sd0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/frpd_checker.sv
`include "framed_remote_packet_decoder_top_assert.svh"

module frpd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_byte_accepted,
  input logic               out_frame_done,
  input logic               out_check_ok,
  input logic               out_remote_enable,
  input logic signed [9:0]  out_wheel_a,
  input logic signed [9:0]  out_wheel_b,
  input logic signed [9:0]  out_wheel_c,
  input logic signed [9:0]  out_wheel_d,
  input logic signed [15:0] out_arm_first_tenths,
  input logic signed [15:0] out_arm_second_tenths,
  input logic signed [15:0] out_arm_third_tenths,
  input logic signed [7:0]  out_grip_value
);

  `FRPD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

  `FRPD_ASSERT_IMP(a_ok_needs_done, out_valid && !out_frame_done, !out_check_ok,
                   "check_ok without a checked frame")

  `FRPD_ASSERT_IMP(a_en_needs_ok, out_valid && !out_check_ok, !out_remote_enable,
                   "remote_enable without a good checksum")

  `FRPD_ASSERT_IMP(a_fields_gated, out_valid && !out_remote_enable,
                   out_wheel_a == 10'sd0 && out_wheel_b == 10'sd0 &&
                   out_wheel_c == 10'sd0 && out_wheel_d == 10'sd0 &&
                   out_arm_first_tenths == 16'sd0 && out_arm_second_tenths == 16'sd0 &&
                   out_arm_third_tenths == 16'sd0 && out_grip_value == 8'sd0,
                   "fields nonzero while not enabled")

  `FRPD_ASSERT_IMP(a_done_accepted, out_valid && out_frame_done, out_byte_accepted,
                   "tail byte not flagged as accepted")

endmodule

bind framed_remote_packet_decoder_top frpd_checker u_frpd_checker (.*);
